// File: design/assert_macros.svh
// Assertion macros used by the checker of the date adder.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GDAD_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDAD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gdad_pkg.sv
// Package for the Gregorian date adder: payload types, FSM states,
// controller/datapath command and status structs, calendar helpers.
// No dependencies.
package gdad_pkg;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int YOE_W     = 9;   // year of era, 0..399
  localparam int ERA_W     = 7;   // signed era count
  localparam int YFULL_W   = 16;  // signed full year while stepping
  localparam int R_W       = 23;  // signed remaining-day count
  localparam int SPAN_BIT  = 21;  // |offset| >= 2**21 always leaves 0..4095

  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 2'd1;

  localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 12'd1800;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 12'd2500;
  localparam logic [YEAR_W-1:0] ERA_YEARS    = 12'd400;
  localparam logic [YOE_W-1:0]  YOE_LAST     = 9'd399;
  localparam logic [YOE_W-1:0]  YEAR_DAYS    = 9'd365;

  localparam logic signed [R_W-1:0]     ERA_DAYS    = 23'sd146097;
  localparam logic signed [R_W-1:0]     ONE_DAY     = 23'sd1;
  localparam logic signed [YFULL_W-1:0] ERA_YEARS_S = 16'sd400;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_BAD_START = 2'd2
  } status_t;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
  } date_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    status_t            status;
  } date_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_BACK,
    S_FWD,
    S_YEAR,
    S_MONTH,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic back_step;
    logic fwd_step;
    logic year_step;
    logic month_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_more;    // working year still >= 400
    logic start_stop;  // bad start or hopeless offset
    logic r_neg;
    logic r_ge_era;
    logic r_ge_year;
    logic r_ge_month;
    logic out_full;
  } dp_stat_t;

  // 4/100/400 rule on the year within its 400-year era
  function automatic logic is_leap(input logic [YOE_W-1:0] yoe);
    return (yoe[1:0] == 2'b00) && (yoe != 9'd100) && (yoe != 9'd200) &&
           (yoe != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    case (m) inside
      MONTH_FEB:                len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/gdad_ctrl.sv
// Controller FSM for the date adder: sequences era split, check,
// era/year/month stepping and result load. Depends on gdad_pkg.
module gdad_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output gdad_pkg::dp_cmd_t  cmd,
  input  gdad_pkg::dp_stat_t stat
);
  import gdad_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid)        state_nxt = S_DIV;
      S_DIV:   if (!stat.div_more)  state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.start_stop ? S_FIN : S_BACK;
      S_BACK:  if (!stat.r_neg)     state_nxt = S_FWD;
      S_FWD:   if (!stat.r_ge_era)  state_nxt = S_YEAR;
      S_YEAR:  if (!stat.r_ge_year) state_nxt = S_MONTH;
      S_MONTH: if (!stat.r_ge_month) state_nxt = S_FIN;
      S_FIN:   if (!stat.out_full)  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load       = in_valid;
      S_DIV:   cmd.div_step   = stat.div_more;
      S_CHECK: cmd.check      = 1'b1;
      S_BACK:  cmd.back_step  = stat.r_neg;
      S_FWD:   cmd.fwd_step   = stat.r_ge_era;
      S_YEAR:  cmd.year_step  = stat.r_ge_year;
      S_MONTH: cmd.month_step = stat.r_ge_month;
      S_FIN:   cmd.finish     = !stat.out_full;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: design/gdad_dp.sv
// Datapath for the date adder: window registers, working date and
// remaining-day count, output register. Depends on gdad_pkg.
module gdad_dp #(
  parameter int OFFSET_BITS = 19
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdad_pkg::dp_cmd_t                   cmd,
  output gdad_pkg::dp_stat_t                  stat,
  input  gdad_pkg::date_in_t                  in_data,
  input  logic [OFFSET_BITS-1:0]              in_day_offset,
  input  logic                                cfg_valid,
  input  logic [gdad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gdad_pkg::YEAR_W-1:0]         cfg_wdata,
  input  logic                                out_stall,
  output logic                                out_valid,
  output gdad_pkg::date_out_t                 out_data
);
  import gdad_pkg::*;

  // wide enough to hold the sign-extended offset and the span check
  localparam int OW_EXT = (OFFSET_BITS > R_W - 1) ? OFFSET_BITS + 1 : R_W;

  logic [YEAR_W-1:0]       year_min_r, year_max_r;
  logic [DAY_W-1:0]        sd_r;
  logic [MONTH_W-1:0]      sm_r, m_r;
  logic [YEAR_W-1:0]       sy_r, ywork_r;
  logic [OFFSET_BITS-1:0]  off_r;
  logic signed [ERA_W-1:0] era_r;
  logic signed [R_W-1:0]   r_r;
  status_t                 err_r;
  logic                    out_valid_r;
  date_out_t               out_data_r;

  logic signed [OW_EXT-1:0]  off_ext;
  logic                      off_big;
  logic signed [R_W-1:0]     r_init;
  logic [YOE_W-1:0]          yoe, yoe_inc;
  logic                      yoe_wrap, leap_cur, leap_next;
  logic [DAY_W-1:0]          ml;
  logic [YOE_W-1:0]          ylen;
  logic                      start_bad;
  logic signed [YFULL_W-1:0] era_ext, year_full;
  logic                      win_bad;
  date_out_t                 result;

  // config window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_min_r <= YEAR_MIN_RST;
      year_max_r <= YEAR_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_YEAR_MIN: year_min_r <= cfg_wdata;
        CFG_YEAR_MAX: year_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign yoe       = ywork_r[YOE_W-1:0];
  assign yoe_wrap  = (yoe == YOE_LAST);
  assign yoe_inc   = yoe_wrap ? '0 : yoe + YOE_W'(1);
  assign leap_cur  = is_leap(yoe);
  assign leap_next = is_leap(yoe_inc);
  assign ml        = month_len(m_r, leap_cur);
  // 1 m Y -> 1 m Y+1 crosses February of Y when m is Jan/Feb
  assign ylen      = YEAR_DAYS + YOE_W'((m_r <= MONTH_FEB) ? leap_cur : leap_next);

  assign off_ext = OW_EXT'($signed(off_r));
  assign off_big = !((&off_ext[OW_EXT-1:SPAN_BIT]) || !(|off_ext[OW_EXT-1:SPAN_BIT]));
  assign r_init  = $signed(off_ext[R_W-1:0]) +
                   $signed({{(R_W-DAY_W){1'b0}}, sd_r}) - ONE_DAY;

  // valid only once ywork_r has been reduced below 400
  assign start_bad = (sy_r < year_min_r) || (sy_r > year_max_r) ||
                     (sm_r == '0) || (sm_r > MONTH_DEC) ||
                     (sd_r == '0) || (sd_r > ml);

  assign era_ext   = YFULL_W'(era_r);
  assign year_full = era_ext * ERA_YEARS_S +
                     $signed({{(YFULL_W-YOE_W){1'b0}}, yoe});
  assign win_bad   = (year_full < $signed({{(YFULL_W-YEAR_W){1'b0}}, year_min_r})) ||
                     (year_full > $signed({{(YFULL_W-YEAR_W){1'b0}}, year_max_r}));

  always_comb begin
    result.result_day   = sd_r;
    result.result_month = sm_r;
    result.result_year  = sy_r;
    result.status       = err_r;
    if (err_r == ST_OK) begin
      if (win_bad) begin
        result.status = ST_RANGE;
      end else begin
        result.result_day   = r_r[DAY_W-1:0] + DAY_W'(1);
        result.result_month = m_r;
        result.result_year  = year_full[YEAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sd_r    <= in_data.start_day;
      sm_r    <= in_data.start_month;
      sy_r    <= in_data.start_year;
      off_r   <= in_day_offset;
      m_r     <= in_data.start_month;
      ywork_r <= in_data.start_year;
      era_r   <= '0;
    end
    if (cmd.div_step) begin
      ywork_r <= ywork_r - ERA_YEARS;
      era_r   <= era_r + ERA_W'(1);
    end
    if (cmd.check) begin
      r_r   <= r_init;
      err_r <= start_bad ? ST_BAD_START : (off_big ? ST_RANGE : ST_OK);
    end
    if (cmd.back_step) begin
      r_r   <= r_r + ERA_DAYS;
      era_r <= era_r - ERA_W'(1);
    end
    if (cmd.fwd_step) begin
      r_r   <= r_r - ERA_DAYS;
      era_r <= era_r + ERA_W'(1);
    end
    if (cmd.year_step) begin
      r_r     <= r_r - $signed({{(R_W-YOE_W){1'b0}}, ylen});
      ywork_r <= {{(YEAR_W-YOE_W){1'b0}}, yoe_inc};
      era_r   <= era_r + ERA_W'(yoe_wrap);
    end
    if (cmd.month_step) begin
      r_r <= r_r - $signed({{(R_W-DAY_W){1'b0}}, ml});
      if (m_r == MONTH_DEC) begin
        m_r     <= MONTH_JAN;
        ywork_r <= {{(YEAR_W-YOE_W){1'b0}}, yoe_inc};
        era_r   <= era_r + ERA_W'(yoe_wrap);
      end else begin
        m_r <= m_r + MONTH_W'(1);
      end
    end
    if (cmd.finish) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.div_more   = (ywork_r >= ERA_YEARS);
  assign stat.start_stop = start_bad || off_big;
  assign stat.r_neg      = r_r[R_W-1];
  assign stat.r_ge_era   = (r_r >= ERA_DAYS);
  assign stat.r_ge_year  = (r_r >= $signed({{(R_W-YOE_W){1'b0}}, ylen}));
  assign stat.r_ge_month = (r_r >= $signed({{(R_W-DAY_W){1'b0}}, ml}));
  assign stat.out_full   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: start date plus signed day count.
// Instantiates gdad_ctrl and gdad_dp; depends on gdad_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_stall   | in_data (date_in_t), in_day_offset
//  out     | out_valid / out_stall | out_data (date_out_t)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_wdata (year window)
//
// Sequence: one request at a time. Era split of the start year, check, era steps,
// year steps, month steps, finish; the worst case is set by the year-step loop
// in the datapath.
// Reset (synchronous, rst_n low): window to 1800..2500, FSM idle, output empty.
// A result held by out_stall blocks the finish of the next request, not its accept.
module gregorian_date_add_days #(
  parameter int OFFSET_BITS = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gdad_pkg::date_in_t             in_data,
  input  logic [OFFSET_BITS-1:0]         in_day_offset,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output gdad_pkg::date_out_t            out_data,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gdad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdad_pkg::YEAR_W-1:0]    cfg_wdata
);
  import gdad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // window registers take a write on any cycle; writes should arrive only when idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  // FSM: walks the stepping phases, at most one datapath command per cycle
  gdad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath: remaining-day count r walks from day 1 of the start month.
  // Negative r borrows whole eras (146097 days), then r is spent by eras,
  // years and months; what is left is the day of month minus one.
  // Year is held as era * 400 + year of era so leap years stay a small decode.
  gdad_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (in_data),
    .in_day_offset (in_day_offset),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

endmodule

// File: design/gdad_checker.sv
// Port-level checker for the date adder, bound to the top level.
// Depends on gdad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gdad_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gdad_pkg::date_out_t out_data
);
  import gdad_pkg::*;

  `GDAD_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `GDAD_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken while busy")

  `GDAD_IMPL(a_result_after_work, $rose(out_valid), $past(in_stall), "result with no request in work")

  `GDAD_IMPL(a_ok_date_sane, out_valid && (out_data.status == ST_OK), (out_data.result_day != '0) && (out_data.result_month != '0) && (out_data.result_month <= MONTH_DEC), "ok result with impossible date")

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/tb_gregorian_date_add_days.sv
`timescale 1ns / 1ps
// Testbench for gregorian_date_add_days: a directed table of dates, then random
// requests under four idle/stall mixes, checked against an in-bench calendar model.
// Depends on gdad_pkg and the date adder RTL; reads no files.
module tb_gregorian_date_add_days;
  import gdad_pkg::*;

  localparam int OFF_W       = 19;
  localparam int OFF_MAX     = 262143;
  localparam int OFF_MIN     = -262144;
  localparam int N_CASES     = 26;
  localparam int PER_PHASE   = 139;      // random requests per idle/stall mix
  localparam int QUIET       = 8;        // settle cycles before a register write
  localparam int DRAIN_WAIT  = 500;      // extra wait after the final drain
  localparam int HOLD_CYCLES = 3000;     // long receiver hold-off in the receiver-stall phase
  localparam int CYCLE_LIMIT = 2000000;  // hang guard limit on simulated cycles

  // Indexes past the two window registers; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // One row of the directed part. When typed is set, the expected result is
  // written in the row; otherwise the calendar model supplies it.
  typedef struct packed {
    int       lo;
    int       hi;
    int       d;
    int       m;
    int       y;
    int       off;
    bit       typed;
    int       wd;
    int       wm;
    int       wy;
    status_t  wst;
  } date_case_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  date_in_t             in_data;
  logic [OFF_W-1:0]     in_day_offset;
  logic                 out_valid;
  logic                 out_stall;
  date_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [YEAR_W-1:0]    cfg_wdata;

  // Bench copy of the year window, tracked on every accepted register write.
  int win_lo = int'(YEAR_MIN_RST);
  int win_hi = int'(YEAR_MAX_RST);

  date_out_t pending_dates[$];  // expected results, oldest first
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;             // set by the stimulus, picked up by the receiver
  int hold_left = 0;

  date_case_t date_cases [N_CASES] = '{
    // reset window 1800..2500: zero offset, month/year roll-over both ways
    '{1800, 2500,  1,  1, 2000,       0, 1,  1,  1, 2000, ST_OK},
    '{1800, 2500, 31, 12, 1999,       1, 1,  1,  1, 2000, ST_OK},
    '{1800, 2500,  1,  3, 2000,      -1, 1, 29,  2, 2000, ST_OK},
    // century year without Feb 29, and the 400-year exception with one
    '{1800, 2500, 28,  2, 1900,       1, 1,  1,  3, 1900, ST_OK},
    '{1800, 2500, 29,  2, 2400,       1, 1,  1,  3, 2400, ST_OK},
    // bad start dates are echoed back
    '{1800, 2500, 29,  2, 1900,       1, 1, 29,  2, 1900, ST_BAD_START},
    '{1800, 2500, 29,  2, 2100,       5, 1, 29,  2, 2100, ST_BAD_START},
    '{1800, 2500,  0,  5, 2000,      10, 1,  0,  5, 2000, ST_BAD_START},
    '{1800, 2500, 10,  0, 2000,      10, 1, 10,  0, 2000, ST_BAD_START},
    '{1800, 2500, 31, 15, 2000,       3, 1, 31, 15, 2000, ST_BAD_START},
    '{1800, 2500, 31,  4, 2000,       1, 1, 31,  4, 2000, ST_BAD_START},
    '{1800, 2500,  1,  1, 1799,       1, 1,  1,  1, 1799, ST_BAD_START},
    '{1800, 2500,  1,  1, 2501,      -1, 1,  1,  1, 2501, ST_BAD_START},
    // one day past either end of the window, a far jump below it, two model rows
    '{1800, 2500,  1,  1, 1800,      -1, 1,  1,  1, 1800, ST_RANGE},
    '{1800, 2500, 31, 12, 2500,       1, 1, 31, 12, 2500, ST_RANGE},
    '{1800, 2500,  1,  1, 2000, OFF_MIN, 1,  1,  1, 2000, ST_RANGE},
    '{1800, 2500, 29,  2, 2004,     365, 0,  0,  0,    0, ST_OK},
    '{1800, 2500, 15,  6, 2100,  -36524, 0,  0,  0,    0, ST_OK},
    // full window 0..4095: falling off year 0 and year 4095, then in-range rows
    '{   0, 4095,  1,  1,    0,      -1, 1,  1,  1,    0, ST_RANGE},
    '{   0, 4095, 31, 12, 4095,       1, 1, 31, 12, 4095, ST_RANGE},
    '{   0, 4095, 29,  2,    0,       1, 1,  1,  3,    0, ST_OK},
    '{   0, 4095,  1,  1, 2000, OFF_MAX, 0,  0,  0,    0, ST_OK},
    '{   0, 4095,  1,  1, 2000, OFF_MIN, 0,  0,  0,    0, ST_OK},
    // inverted window: nothing is a valid start
    '{2500, 1800,  1,  1, 2000,       5, 1,  1,  1, 2000, ST_BAD_START},
    // single-year window, leap year 2000 has 366 days
    '{2000, 2000, 31, 12, 2000,       1, 1, 31, 12, 2000, ST_RANGE},
    '{2000, 2000,  1,  1, 2000,     365, 1, 31, 12, 2000, ST_OK}
  };

  gregorian_date_add_days #(
    .OFFSET_BITS(OFF_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .in_day_offset(in_day_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar model. Years are shifted up by 400 so that every quantity stays
  // non-negative; the leap rule repeats every 400 years, so the shift is free.
  // ---------------------------------------------------------------------------
  function automatic bit leap_yr(int sy);
    return ((sy % 4 == 0) && (sy % 100 != 0)) || (sy % 400 == 0);
  endfunction

  function automatic int days_in_month_of(int m, int sy);
    case (m)
      2:           return leap_yr(sy) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Days from 1 March of shifted year 0 to 1 March of shifted year sy.
  // A March-based year carries the Feb 29 of the following calendar year.
  function automatic longint march_first(longint sy);
    return 365 * sy + sy / 4 - sy / 100 + sy / 400;
  endfunction

  // Day number of a calendar date, counted from 1 March of shifted year 0.
  function automatic longint day_index(int d, int m, int y);
    longint n;
    int     sy;
    sy = y + 400;
    if (m >= 3) begin
      n = march_first(sy);
      for (int k = 3; k < m; k++) n += days_in_month_of(k, sy);
    end else begin
      // Jan/Feb close the March-based year that began a year earlier;
      // March..December hold 306 days.
      n = march_first(sy - 1) + 306;
      if (m == 2) n += 31;
    end
    return n + d - 1;
  endfunction

  // Expected result of one request under the current window.
  function automatic date_out_t add_days_to_date(date_in_t s, logic [OFF_W-1:0] off);
    date_out_t r;
    int        d;
    int        m;
    int        y;
    int        mo;
    int        yr;
    longint    n;
    longint    sy;
    longint    rem;
    d = int'(s.start_day);
    m = int'(s.start_month);
    y = int'(s.start_year);
    r.result_day   = s.start_day;
    r.result_month = s.start_month;
    r.result_year  = s.start_year;
    r.status       = ST_OK;
    if (win_lo > win_hi || y < win_lo || y > win_hi || m < 1 || m > 12 ||
        d < 1 || d > days_in_month_of(m, y + 400)) begin
      r.status = ST_BAD_START;
    end else begin
      n = day_index(d, m, y) + longint'($signed(off));
      if (n < 0) begin
        r.status = ST_RANGE;
      end else begin
        // estimate the March-based year, then correct by whole years
        sy = n * 400 / 146097;
        while (march_first(sy + 1) <= n) sy++;
        while (march_first(sy) > n) sy--;
        rem = n - march_first(sy);
        mo = 3;
        yr = int'(sy) - 400;
        while (rem >= days_in_month_of(mo, yr + 400)) begin
          rem -= days_in_month_of(mo, yr + 400);
          mo++;
          if (mo > 12) begin
            mo = 1;
            yr++;
          end
        end
        if (yr < win_lo || yr > win_hi) begin
          r.status = ST_RANGE;
        end else begin
          r.result_day   = DAY_W'(rem + 1);
          r.result_month = MONTH_W'(mo);
          r.result_year  = YEAR_W'(yr);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. All drives happen at the falling edge; handshakes are
  // sampled at the rising edge, before the block's registers update.
  // ---------------------------------------------------------------------------

  // Offers one request, holding it steady until accepted. in_valid stays high
  // on return so back-to-back requests need no extra edge on it.
  task automatic offer_request(input date_in_t s, input logic [OFF_W-1:0] off,
                               input bit typed, input date_out_t typed_res);
    bit taken;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_data       = s;
    in_day_offset = off;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    // The block holds no state across requests besides the window, so the
    // expectation can be fixed at acceptance.
    pending_dates.push_back(typed ? typed_res : add_days_to_date(s, off));
    @(negedge clk);
  endtask

  // Lets the block go idle: every expected result has arrived.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
    repeat (QUIET) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = YEAR_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_YEAR_MIN) win_lo = val;
    else if (idx == CFG_YEAR_MAX) win_hi = val;
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed dates inside the window with offsets of mixed reach;
  // the rest is raw noise on every field.
  task automatic random_request();
    date_in_t s;
    int       y;
    int       m;
    int       d;
    int       o;
    int       span;
    if (win_lo <= win_hi && $urandom_range(99) < 80) begin
      y = int'($urandom_range(win_hi, win_lo));
      m = int'($urandom_range(12, 1));
      d = int'($urandom_range(days_in_month_of(m, y + 400), 1));
      case ($urandom_range(4))
        0: o = int'($urandom_range(80)) - 40;
        1: o = int'($urandom_range(4000)) - 2000;
        2: begin
          // about the width of the window, so both status outcomes show up
          span = (win_hi - win_lo + 1) * 366;
          o = int'($urandom_range(2 * span)) - span;
          if (o > OFF_MAX) o = OFF_MAX;
          if (o < OFF_MIN) o = OFF_MIN;
        end
        3: begin
          // start on the first or last day of the window
          if ($urandom_range(1) == 0) begin
            y = win_lo;
            m = 1;
            d = 1;
          end else begin
            y = win_hi;
            m = 12;
            d = 31;
          end
          o = int'($urandom_range(800)) - 400;
        end
        default: o = int'($urandom);
      endcase
      s.start_day   = DAY_W'(d);
      s.start_month = MONTH_W'(m);
      s.start_year  = YEAR_W'(y);
    end else begin
      s.start_day   = DAY_W'($urandom);
      s.start_month = MONTH_W'($urandom);
      s.start_year  = YEAR_W'($urandom);
      o = int'($urandom);
    end
    offer_request(s, OFF_W'(o), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus a long hold-off on request, counted here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = int'($urandom_range(99)) < recv_stall_pct;
    end
  end

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    date_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %0d-%0d-%0d st %0d",
                 $time, out_data.result_year, out_data.result_month,
                 out_data.result_day, out_data.status);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        compare_field("result_day",   int'(want.result_day),   int'(out_data.result_day));
        compare_field("result_month", int'(want.result_month), int'(out_data.result_month));
        compare_field("result_year",  int'(want.result_year),  int'(out_data.result_year));
        compare_field("status",       int'(want.status),       int'(out_data.status));
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, four random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    date_in_t  s;
    date_out_t want;
    int        lo;
    int        hi;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_day_offset = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_YEAR_MIN;
    cfg_wdata     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed part runs at full rate; the first rows rely on the reset window.
    foreach (date_cases[i]) begin
      if (date_cases[i].lo != win_lo || date_cases[i].hi != win_hi) begin
        wait_drained();
        write_reg(CFG_YEAR_MIN, date_cases[i].lo);
        write_reg(CFG_YEAR_MAX, date_cases[i].hi);
      end
      s.start_day   = DAY_W'(date_cases[i].d);
      s.start_month = MONTH_W'(date_cases[i].m);
      s.start_year  = YEAR_W'(date_cases[i].y);
      want = date_out_t'{DAY_W'(date_cases[i].wd), MONTH_W'(date_cases[i].wm),
                         YEAR_W'(date_cases[i].wy), date_cases[i].wst};
      offer_request(s, OFF_W'(date_cases[i].off), date_cases[i].typed, want);
    end

    // Phases: no idling / sender idle / receiver stall / both.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          lo = int'($urandom_range(1500));
          hi = lo + int'($urandom_range(900, 40));
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
          lo = 0;
          hi = 4095;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
          lo = int'($urandom_range(3900, 2000));
          hi = int'($urandom_range(4095, lo));
        end
        default: begin
          // narrow window: most results fall out of it
          send_idle_pct  = 38;
          recv_stall_pct = 38;
          lo = int'($urandom_range(4000));
          hi = lo + int'($urandom_range(60));
        end
      endcase
      // unused indexes first: the window must survive them
      write_reg(CFG_SPARE_2, int'($urandom_range(4095)));
      write_reg(CFG_SPARE_3, int'($urandom_range(4095)));
      write_reg(CFG_YEAR_MIN, lo);
      write_reg(CFG_YEAR_MAX, hi);
      // Receiver goes quiet while requests keep coming: the output register
      // fills, the next request finishes behind it and the input stalls.
      if (ph == 2) hold_ask = HOLD_CYCLES;
      repeat (PER_PHASE) random_request();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
